// ----- rtl/ctpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpq_pkg
// Shared widths, status codes and the queue entry layout of the CAN transmit
// priority queue.
// ----------------------------------------------------------------------------
package ctpq_pkg;

    localparam int IDENT_W   = 29;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int RETRY_W   = 8;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = 32;
    localparam int PRIO_IN_W = 3;

    localparam int DEF_QUEUE_DEPTH    = 8;
    localparam int DEF_NUM_PRIORITIES = 4;

    localparam logic [LEN_W-1:0] MAX_DLC = 4'd8;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_SVC = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SENDFAIL = 3'd5;

    typedef struct packed {
        logic [IDENT_W-1:0]   ident;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
        logic [RETRY_W-1:0]   retries;
        logic [TIME_W-1:0]    deadline;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/ctpq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpq_if
// Valid/ready channels of the CAN transmit priority queue: the command word
// channel and the result word channel.
// ----------------------------------------------------------------------------
interface ctpq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ctpq_pkg::PRIO_IN_W-1:0] prio_level;
    logic [ctpq_pkg::IDENT_W-1:0]   frame_ident;
    logic [ctpq_pkg::LEN_W-1:0]     frame_len;
    logic [ctpq_pkg::PAYLOAD_W-1:0] frame_payload;
    logic [ctpq_pkg::RETRY_W-1:0]   retry_budget;
    logic [ctpq_pkg::TIME_W-1:0]    deadline_time;
    logic [ctpq_pkg::TIME_W-1:0]    now_time;
    logic                          send_ok;

    modport source (
        output valid, cmd, prio_level, frame_ident, frame_len, frame_payload,
               retry_budget, deadline_time, now_time, send_ok,
        input  ready
    );
    modport sink (
        input  valid, cmd, prio_level, frame_ident, frame_len, frame_payload,
               retry_budget, deadline_time, now_time, send_ok,
        output ready
    );
endinterface

interface ctpq_out_if;
    logic                           valid;
    logic                           ready;
    logic [ctpq_pkg::STATUS_W-1:0]  status_code;
    logic                           tx_attempt;
    logic [ctpq_pkg::IDENT_W-1:0]   out_ident;
    logic [ctpq_pkg::LEN_W-1:0]     out_len;
    logic [ctpq_pkg::PAYLOAD_W-1:0] out_payload;
    logic [ctpq_pkg::CNT_W-1:0]     enqueued_total;
    logic [ctpq_pkg::CNT_W-1:0]     sent_total;
    logic [ctpq_pkg::CNT_W-1:0]     dropped_total;
    logic [ctpq_pkg::CNT_W-1:0]     expired_total;
    logic [ctpq_pkg::CNT_W-1:0]     retry_total;

    modport source (
        output valid, status_code, tx_attempt, out_ident, out_len, out_payload,
               enqueued_total, sent_total, dropped_total, expired_total,
               retry_total,
        input  ready
    );
    modport sink (
        input  valid, status_code, tx_attempt, out_ident, out_len, out_payload,
               enqueued_total, sent_total, dropped_total, expired_total,
               retry_total,
        output ready
    );
endinterface

// ----- rtl/ctpq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ctpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/can_tx_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_tx_priority_queue
// Strict-priority CAN transmit queue: one ring FIFO per priority level held in
// a shared entry RAM, with five wrapping event counters.
// ----------------------------------------------------------------------------
// Every command word passes S_IDLE, where the accept picks the queue and issues
// the entry RAM read of its head, then S_EXEC, which checks an enqueue (length,
// priority, room) or evaluates the head (deadline, send result, retry budget),
// writes the entry RAM where needed and loads the result word, a split set by
// the registered RAM read. An untaken result word holds it in S_EXEC until taken.
// The RAM needs no clearing after reset; only occupied entries are ever evaluated.
// ----------------------------------------------------------------------------
module can_tx_priority_queue #(
    parameter int QUEUE_DEPTH    = ctpq_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_PRIORITIES = ctpq_pkg::DEF_NUM_PRIORITIES
) (
    input  logic       clk,
    input  logic       rst_n,
    ctpq_in_if.sink    item,
    ctpq_out_if.source result
);

    import ctpq_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int SLOTS  = NUM_PRIORITIES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    localparam logic [PTR_W-1:0]     PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0]    QD_ADDR   = ADDR_W'(QUEUE_DEPTH);
    localparam logic [PRIO_IN_W:0]   NUM_PRIO  = (PRIO_IN_W + 1)'(NUM_PRIORITIES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    logic [PTR_W-1:0]  wr_ptr_reg [NUM_PRIORITIES];
    logic [PTR_W-1:0]  rd_ptr_reg [NUM_PRIORITIES];
    logic [FILL_W-1:0] fill_reg   [NUM_PRIORITIES];

    logic [CNT_W-1:0] enq_cnt_reg,    enq_cnt_next;
    logic [CNT_W-1:0] sent_cnt_reg,   sent_cnt_next;
    logic [CNT_W-1:0] drop_cnt_reg,   drop_cnt_next;
    logic [CNT_W-1:0] expire_cnt_reg, expire_cnt_next;
    logic [CNT_W-1:0] retry_cnt_reg,  retry_cnt_next;

    logic                  cmd_reg;
    logic [PRIO_IN_W-1:0]  prio_reg;
    logic [IDENT_W-1:0]    ident_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [PAYLOAD_W-1:0]  payload_reg;
    logic [RETRY_W-1:0]    budget_reg;
    logic [TIME_W-1:0]     deadline_reg;
    logic [TIME_W-1:0]     now_reg;
    logic                  ok_reg;
    logic [PRIO_W-1:0]     head_q_reg;
    logic                  head_found_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg,    status_next;
    logic                  attempt_reg,   attempt_next;
    logic [IDENT_W-1:0]    o_ident_reg,   o_ident_next;
    logic [LEN_W-1:0]      o_len_reg,     o_len_next;
    logic [PAYLOAD_W-1:0]  o_payload_reg, o_payload_next;

    logic              accept;
    logic              fire;
    logic [PRIO_W-1:0] head_q;
    logic              head_found;
    logic [ADDR_W-1:0] head_addr;
    logic [PRIO_W-1:0] q_sel;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              prio_ok;
    logic              push;
    logic              pop;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    entry_t            head_entry;
    logic [ENTRY_W-1:0] ram_rdata;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign fire = (state_reg == S_EXEC) && (!out_valid_reg || result.ready);

    always_comb
    begin
        head_q     = '0;
        head_found = 1'b0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0)
            begin
                head_q     = PRIO_W'(i);
                head_found = 1'b1;
            end
        end
    end

    assign head_addr = ADDR_W'(head_q) * QD_ADDR + ADDR_W'(rd_ptr_reg[head_q]);

    ctpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    assign head_entry = entry_t'(ram_rdata);

    assign q_sel   = (cmd_reg == CMD_SVC) ? head_q_reg : prio_reg[PRIO_W-1:0];
    assign wr_addr = ADDR_W'(q_sel) * QD_ADDR + ADDR_W'(wr_ptr_reg[q_sel]);
    assign rd_addr = ADDR_W'(q_sel) * QD_ADDR + ADDR_W'(rd_ptr_reg[q_sel]);
    assign prio_ok = {1'b0, prio_reg} < NUM_PRIO;

    always_comb
    begin
        push            = 1'b0;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_addr;
        ram_wdata       = head_entry;
        enq_cnt_next    = enq_cnt_reg;
        sent_cnt_next   = sent_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        expire_cnt_next = expire_cnt_reg;
        retry_cnt_next  = retry_cnt_reg;
        status_next     = status_reg;
        attempt_next    = attempt_reg;
        o_ident_next    = o_ident_reg;
        o_len_next      = o_len_reg;
        o_payload_next  = o_payload_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        state_next      = state_reg;

        if (accept)
        begin
            state_next = S_EXEC;
        end

        if (fire)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            attempt_next   = 1'b0;
            o_ident_next   = '0;
            o_len_next     = '0;
            o_payload_next = '0;
            if (cmd_reg == CMD_ENQ)
            begin
                priority if (len_reg > MAX_DLC || !prio_ok)
                begin
                    status_next = ST_INVALID;
                end
                else if (fill_reg[q_sel] >= FILL_FULL)
                begin
                    drop_cnt_next = drop_cnt_reg + 1'b1;
                    status_next   = ST_FULL;
                end
                else
                begin
                    push              = 1'b1;
                    ram_we            = 1'b1;
                    ram_waddr         = wr_addr;
                    ram_wdata.ident    = ident_reg;
                    ram_wdata.len      = len_reg;
                    ram_wdata.payload  = payload_reg;
                    ram_wdata.retries  = budget_reg;
                    ram_wdata.deadline = deadline_reg;
                    enq_cnt_next      = enq_cnt_reg + 1'b1;
                    status_next       = ST_OK;
                end
            end
            else
            begin
                priority if (!head_found_reg)
                begin
                    status_next = ST_EMPTY;
                end
                else if (head_entry.deadline != '0 && now_reg > head_entry.deadline)
                begin
                    pop             = 1'b1;
                    expire_cnt_next = expire_cnt_reg + 1'b1;
                    drop_cnt_next   = drop_cnt_reg + 1'b1;
                    status_next     = ST_EXPIRED;
                end
                else
                begin
                    attempt_next   = 1'b1;
                    o_ident_next   = head_entry.ident;
                    o_len_next     = head_entry.len;
                    o_payload_next = head_entry.payload;
                    priority if (ok_reg)
                    begin
                        pop           = 1'b1;
                        sent_cnt_next = sent_cnt_reg + 1'b1;
                        status_next   = ST_OK;
                    end
                    else if (head_entry.retries != '0)
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = rd_addr;
                        ram_wdata.retries = head_entry.retries - 1'b1;
                        retry_cnt_next    = retry_cnt_reg + 1'b1;
                        status_next       = ST_SENDFAIL;
                    end
                    else
                    begin
                        pop           = 1'b1;
                        drop_cnt_next = drop_cnt_reg + 1'b1;
                        status_next   = ST_SENDFAIL;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            enq_cnt_reg    <= '0;
            sent_cnt_reg   <= '0;
            drop_cnt_reg   <= '0;
            expire_cnt_reg <= '0;
            retry_cnt_reg  <= '0;
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            enq_cnt_reg    <= enq_cnt_next;
            sent_cnt_reg   <= sent_cnt_next;
            drop_cnt_reg   <= drop_cnt_next;
            expire_cnt_reg <= expire_cnt_next;
            retry_cnt_reg  <= retry_cnt_next;
            if (push)
            begin
                wr_ptr_reg[q_sel] <= (wr_ptr_reg[q_sel] == PTR_LAST) ? '0
                                     : wr_ptr_reg[q_sel] + 1'b1;
                fill_reg[q_sel]   <= fill_reg[q_sel] + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg[q_sel] <= (rd_ptr_reg[q_sel] == PTR_LAST) ? '0
                                     : rd_ptr_reg[q_sel] + 1'b1;
                fill_reg[q_sel]   <= fill_reg[q_sel] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= item.cmd;
            prio_reg       <= item.prio_level;
            ident_reg      <= item.frame_ident;
            len_reg        <= item.frame_len;
            payload_reg    <= item.frame_payload;
            budget_reg     <= item.retry_budget;
            deadline_reg   <= item.deadline_time;
            now_reg        <= item.now_time;
            ok_reg         <= item.send_ok;
            head_q_reg     <= head_q;
            head_found_reg <= head_found;
        end
        status_reg    <= status_next;
        attempt_reg   <= attempt_next;
        o_ident_reg   <= o_ident_next;
        o_len_reg     <= o_len_next;
        o_payload_reg <= o_payload_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.status_code    = status_reg;
    assign result.tx_attempt     = attempt_reg;
    assign result.out_ident      = o_ident_reg;
    assign result.out_len        = o_len_reg;
    assign result.out_payload    = o_payload_reg;
    assign result.enqueued_total = enq_cnt_reg;
    assign result.sent_total     = sent_cnt_reg;
    assign result.dropped_total  = drop_cnt_reg;
    assign result.expired_total  = expire_cnt_reg;
    assign result.retry_total    = retry_cnt_reg;

endmodule
